FILE: rtl/core/rcf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rcf_pkg
// Shared types, constants and the RGBI to RGB565 color function.
// ----------------------------------------------------------------------------
package rcf_pkg;

   // output window size
   localparam int OUT_WIDTH  = 320;
   localparam int OUT_HEIGHT = 240;

   localparam int CNT_W   = 10;
   localparam int CODE_W  = 8;
   localparam int COLOR_W = 16;
   localparam int ROW_W   = 8;
   localparam int COL_W   = 9;
   localparam int IDX_W   = 2;

   localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

   localparam int RES_W      = COLOR_W + ROW_W + COL_W;
   localparam int RSP_DATA_W = ((RES_W + 7) / 8) * 8;
   localparam int RSP_PAD_W  = RSP_DATA_W - RES_W;

   // register indexes
   localparam logic [IDX_W-1:0] REG_LINE_LENGTH  = 2'd0;
   localparam logic [IDX_W-1:0] REG_FIRST_LINE   = 2'd1;
   localparam logic [IDX_W-1:0] REG_FIRST_COLUMN = 2'd2;

   localparam logic [CNT_W-1:0] RESET_LINE_LENGTH  = 10'd432;
   localparam logic [CNT_W-1:0] RESET_FIRST_LINE   = 10'd42;
   localparam logic [CNT_W-1:0] RESET_FIRST_COLUMN = 10'd88;

   // color levels
   localparam logic [4:0] LEVEL_RB     = 5'd15;
   localparam logic [4:0] LEVEL_RB_HI  = 5'd30;
   localparam logic [5:0] LEVEL_G      = 6'd30;
   localparam logic [5:0] LEVEL_G_HI   = 6'd60;

   // code bits
   localparam int BIT_RED    = 0;
   localparam int BIT_GREEN  = 1;
   localparam int BIT_BLUE   = 2;
   localparam int BIT_BRIGHT = 3;

   typedef struct packed {
      logic [CNT_W-1:0] line_length;
      logic [CNT_W-1:0] first_line;
      logic [CNT_W-1:0] first_column;
   } cfg_type;

   typedef struct packed {
      logic [3:0]       code;
      logic [CNT_W-1:0] line;
      logic [CNT_W-1:0] column;
   } pos_type;

   // color sits in the low bits
   typedef struct packed {
      logic [COL_W-1:0]   out_column;
      logic [ROW_W-1:0]   out_row;
      logic [COLOR_W-1:0] color;
   } res_type;

   function automatic logic [COLOR_W-1:0] rgbi_to_565(input logic [3:0] code);
      logic [4:0] r;
      logic [5:0] g;
      logic [4:0] b;
      r = code[BIT_RED]   ? (code[BIT_BRIGHT] ? LEVEL_RB_HI : LEVEL_RB) : 5'd0;
      g = code[BIT_GREEN] ? (code[BIT_BRIGHT] ? LEVEL_G_HI  : LEVEL_G)  : 6'd0;
      b = code[BIT_BLUE]  ? (code[BIT_BRIGHT] ? LEVEL_RB_HI : LEVEL_RB) : 5'd0;
      return {r, g, b};
   endfunction

endpackage
`default_nettype wire

FILE: rtl/core/rcf_csr.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rcf_csr
// Configuration registers: stride and window origin.
// ----------------------------------------------------------------------------
module rcf_csr (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      csr_valid,
   output logic                           csr_ready,
   input  wire logic [rcf_pkg::IDX_W-1:0] csr_index,
   input  wire logic [rcf_pkg::CNT_W-1:0] csr_data,
   output rcf_pkg::cfg_type               cfg
);
   import rcf_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            REG_LINE_LENGTH:  cfg_in.line_length  = csr_data;
            REG_FIRST_LINE:   cfg_in.first_line   = csr_data;
            REG_FIRST_COLUMN: cfg_in.first_column = csr_data;
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.line_length  <= RESET_LINE_LENGTH;
         cfg_ff.first_line   <= RESET_FIRST_LINE;
         cfg_ff.first_column <= RESET_FIRST_COLUMN;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule
`default_nettype wire

FILE: rtl/core/rcf_position.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rcf_position
// Input register with raster line and column counters.
// ----------------------------------------------------------------------------
module rcf_position (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic [rcf_pkg::CNT_W-1:0]  line_length,
   input  wire logic                       req_tvalid,
   output logic                            req_tready,
   input  wire logic [rcf_pkg::CODE_W-1:0] req_tdata,
   input  wire logic                       req_tuser,
   output logic                            pos_valid,
   input  wire logic                       pos_ready,
   output rcf_pkg::pos_type                pos
);
   import rcf_pkg::*;

   logic             accept;
   logic [CNT_W-1:0] line_ff, line_in;
   logic [CNT_W-1:0] column_ff, column_in;
   logic             valid_ff, valid_in;
   pos_type          pos_ff, pos_in;
   logic [CNT_W-1:0] line_cur, column_cur;
   logic [CNT_W:0]   column_next;

   assign req_tready = !valid_ff || pos_ready;
   assign accept     = req_tvalid && req_tready;
   assign pos_valid  = valid_ff;
   assign pos        = pos_ff;

   always_comb begin
      // frame mark puts this pixel at line 0, column 0
      line_cur    = req_tuser ? '0 : line_ff;
      column_cur  = req_tuser ? '0 : column_ff;
      column_next = {1'b0, column_cur} + 1'b1;

      line_in   = line_ff;
      column_in = column_ff;
      pos_in    = pos_ff;
      valid_in  = valid_ff;
      if (pos_ready) begin
         valid_in = 1'b0;
      end
      if (accept) begin
         valid_in      = 1'b1;
         pos_in.code   = req_tdata[3:0];
         pos_in.line   = line_cur;
         pos_in.column = column_cur;
         if (column_next >= {1'b0, line_length}) begin
            column_in = '0;
            line_in   = (line_cur == CNT_MAX) ? line_cur : line_cur + 1'b1;
         end else begin
            column_in = column_next[CNT_W-1:0];
            line_in   = line_cur;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         line_ff   <= '0;
         column_ff <= '0;
         valid_ff  <= 1'b0;
      end else begin
         line_ff   <= line_in;
         column_ff <= column_in;
         valid_ff  <= valid_in;
      end
      pos_ff <= pos_in;
   end

endmodule
`default_nettype wire

FILE: rtl/core/rcf_map.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rcf_map
// Window test, flipped output coordinates and RGB565 color.
// ----------------------------------------------------------------------------
module rcf_map (
   input  rcf_pkg::cfg_type cfg,
   input  rcf_pkg::pos_type pos,
   output logic             hit,
   output rcf_pkg::res_type res
);
   import rcf_pkg::*;

   localparam logic [CNT_W:0]   HEIGHT_EXT = (CNT_W+1)'(OUT_HEIGHT);
   localparam logic [CNT_W:0]   WIDTH_EXT  = (CNT_W+1)'(OUT_WIDTH);
   localparam logic [CNT_W-1:0] ROW_LAST   = CNT_W'(OUT_HEIGHT - 1);

   logic [CNT_W:0]   line_end, column_end;
   logic [CNT_W-1:0] win_row, win_column, row_flip;

   always_comb begin
      line_end   = {1'b0, cfg.first_line} + HEIGHT_EXT;
      column_end = {1'b0, cfg.first_column} + WIDTH_EXT;
      hit = (pos.line >= cfg.first_line) && ({1'b0, pos.line} < line_end) &&
            (pos.column >= cfg.first_column) && ({1'b0, pos.column} < column_end);
      win_row    = pos.line - cfg.first_line;
      win_column = pos.column - cfg.first_column;
      row_flip   = ROW_LAST - win_row;
      res.color      = rgbi_to_565(pos.code);
      res.out_row    = row_flip[ROW_W-1:0];
      res.out_column = win_column[COL_W-1:0];
   end

endmodule
`default_nettype wire

FILE: rtl/core/rcf_result.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rcf_result
// Result register toward the output stream; misses are dropped here.
// ----------------------------------------------------------------------------
module rcf_result (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           pos_valid,
   output logic                                pos_ready,
   input  wire logic                           hit,
   input  rcf_pkg::res_type                    res,
   output logic                                rsp_tvalid,
   input  wire logic                           rsp_tready,
   output logic [rcf_pkg::RSP_DATA_W-1:0]      rsp_tdata
);
   import rcf_pkg::*;

   logic    valid_ff, valid_in;
   res_type res_ff, res_in;

   assign pos_ready  = !valid_ff || rsp_tready;
   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {{RSP_PAD_W{1'b0}}, res_ff};

   always_comb begin
      valid_in = valid_ff;
      res_in   = res_ff;
      if (pos_ready) begin
         valid_in = pos_valid && hit;
         res_in   = res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      res_ff <= res_in;
   end

endmodule
`default_nettype wire

FILE: rtl/core/rgbi_crop_flip_to_rgb565.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rgbi_crop_flip_to_rgb565
// Crops an RGBI pixel stream to a window, flips it vertically, emits RGB565.
// ----------------------------------------------------------------------------
// Takes one pixel beat per clock unless the result stream stalls, and gives at
// most one result beat per pixel. The rate is set by the line and column
// counter update, which finishes in the cycle a pixel is accepted; the window
// test and color lookup sit between the input register and the result
// register. Pixels outside the window give no beat. Registers: 0 line length,
// 1 first line, 2 first column; write them only while the stream is idle.
module rgbi_crop_flip_to_rgb565 (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_tvalid,
   output logic                                req_tready,
   input  wire logic [rcf_pkg::CODE_W-1:0]     req_tdata,  // pixel_code
   input  wire logic                           req_tuser,  // frame_start
   output logic                                rsp_tvalid,
   input  wire logic                           rsp_tready,
   // color[15:0], out_row[23:16], out_column[32:24], zero pad
   output logic [rcf_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   input  wire logic                           csr_valid,
   output logic                                csr_ready,
   input  wire logic [rcf_pkg::IDX_W-1:0]      csr_index,
   input  wire logic [rcf_pkg::CNT_W-1:0]      csr_data
);
   import rcf_pkg::*;

   cfg_type cfg;
   pos_type pos;
   res_type res;
   logic    pos_valid, pos_ready, hit;

   rcf_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   rcf_position u_position (
      .clock       (clock),
      .reset       (reset),
      .line_length (cfg.line_length),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .pos_valid   (pos_valid),
      .pos_ready   (pos_ready),
      .pos         (pos)
   );

   rcf_map u_map (
      .cfg (cfg),
      .pos (pos),
      .hit (hit),
      .res (res)
   );

   rcf_result u_result (
      .clock      (clock),
      .reset      (reset),
      .pos_valid  (pos_valid),
      .pos_ready  (pos_ready),
      .hit        (hit),
      .res        (res),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule
`default_nettype wire

FILE: rtl/core/rcf_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rcf_checker
// Port-level checks on the result stream.
// ----------------------------------------------------------------------------
module rcf_checker (
   input wire logic                           clock,
   input wire logic                           reset,
   input wire logic                           rsp_tvalid,
   input wire logic                           rsp_tready,
   input wire logic [rcf_pkg::RSP_DATA_W-1:0] rsp_tdata
);
   import rcf_pkg::*;

   // no beat can be pending right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result beat valid after reset");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result beat changed");

   // coordinates stay inside the output frame, pad bits stay zero
   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[23:16] < ROW_W'(OUT_HEIGHT)) &&
                     (rsp_tdata[32:24] < COL_W'(OUT_WIDTH)) &&
                     (rsp_tdata[RSP_DATA_W-1:RES_W] == '0))
      else $error("result coordinates out of range");

   // red and blue only take the three palette levels
   a_levels: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[15:11] == 5'd0 || rsp_tdata[15:11] == LEVEL_RB ||
                      rsp_tdata[15:11] == LEVEL_RB_HI) &&
                     (rsp_tdata[4:0] == 5'd0 || rsp_tdata[4:0] == LEVEL_RB ||
                      rsp_tdata[4:0] == LEVEL_RB_HI))
      else $error("color level outside palette");

endmodule

bind rgbi_crop_flip_to_rgb565 rcf_checker u_rcf_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
`default_nettype wire
